// ----- hw/rtl/gra_pkg.sv -----
// Shared constants, codes and control types for the grid rectangle allocator.
`default_nettype none

package gra_pkg;

    localparam int DEF_MAX_WIDTH  = 16;
    localparam int DEF_MAX_HEIGHT = 16;

    localparam int OP_W       = 2;
    localparam int POS_W      = 4;
    localparam int SIZE_W     = 5;
    localparam int GRID_W     = 5;
    localparam int ALLOW_W    = 9;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 9;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
    localparam logic [OP_W-1:0] OP_PROBE = 2'd2;
    localparam logic [OP_W-1:0] OP_PLACE = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_WIDTH    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_HEIGHT   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALLOWED_CELLS = 2'd2;

    localparam logic [GRID_W-1:0]  RST_GRID_WIDTH    = 5'd16;
    localparam logic [GRID_W-1:0]  RST_GRID_HEIGHT   = 5'd16;
    localparam logic [ALLOW_W-1:0] RST_ALLOWED_CELLS = 9'd0;

    typedef struct packed {
        logic              clear;
        logic              row_valid;
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
    } fit_ctl_t;

    typedef struct packed {
        logic busy;
        logic hit;
    } fit_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/grid_rect_first_fit_allocator.sv -----
// Top level: command sequencer for clear, mark, probe and place over the occupancy memory.
// One command at a time. Clear writes every memory word in turn.
// Probe reads one grid row per cycle (two memory words), then drains the search pipeline.
// Mark reads, then writes back, each memory word touched in each rectangle row;
// place runs a probe and, on a hit, a mark at the fit position.
// Async reset clears control and config (16, 16, 0); per-word valid bits make the grid free.
`default_nettype none

module grid_rect_first_fit_allocator #(
    parameter int MAX_WIDTH  = gra_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gra_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [gra_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [gra_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // operation[1:0], pos_x[5:2], pos_y[9:6], size_x[14:10], size_y[19:15], zero[23:20]
    input  wire logic [gra_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // found[0], found_x[4:1], found_y[8:5], zero[15:9]
    output logic      [gra_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    localparam int SW     = gra_pkg::SIZE_W;
    localparam int PW     = gra_pkg::POS_W;
    localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int EWW    = $clog2(MAX_WIDTH + 1);
    localparam int EHW    = $clog2(MAX_HEIGHT + 1);
    localparam int LW     = CW;
    localparam int WW     = 1 << LW;
    localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
    localparam int NWORDS = (CELLS + WW - 1) / WW + 2;
    localparam int AW     = $clog2(NWORDS);
    localparam int IW     = $clog2((MAX_HEIGHT + 64) * (MAX_WIDTH + 64));
    localparam int XW     = (CW > PW) ? CW : PW;
    localparam int YW     = (RW > PW) ? RW : PW;
    localparam int DW     = RW + SW + 1;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SETUP = 4'd1;
    localparam logic [3:0] ST_CLEAR = 4'd2;
    localparam logic [3:0] ST_SCAN  = 4'd3;
    localparam logic [3:0] ST_DRAIN = 4'd4;
    localparam logic [3:0] ST_MSET  = 4'd5;
    localparam logic [3:0] ST_MROW  = 4'd6;
    localparam logic [3:0] ST_MRD   = 4'd7;
    localparam logic [3:0] ST_MWR   = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    logic [gra_pkg::GRID_W-1:0]  gw_reg;
    logic [gra_pkg::GRID_W-1:0]  gh_reg;
    logic [gra_pkg::ALLOW_W-1:0] allowed_reg;

    logic [gra_pkg::OP_W-1:0] op_reg;
    logic [XW-1:0]            px_reg;
    logic [YW-1:0]            py_reg;
    logic [SW-1:0]            sx_reg;
    logic [SW-1:0]            sy_reg;
    logic [EWW-1:0]           w_reg;
    logic [EHW-1:0]           h_reg;
    logic [EWW-1:0]           w_c;
    logic [EHW-1:0]           h_c;

    logic [IW-1:0] total_reg;
    logic [IW-1:0] total_c;
    logic [IW-1:0] clr_lo_reg;
    logic [IW-1:0] base_reg;
    logic [IW-1:0] lim_reg;
    logic [IW-1:0] lim_c;
    logic [IW-1:0] lim_m1;
    logic [IW-1:0] srow_reg;
    logic [AW-1:0] wa_reg;
    logic [SW-1:0] ycnt_reg;
    logic [RW-1:0] rq_reg;
    logic          search_empty;

    logic          p1_valid_reg;
    logic [RW-1:0] p1_row_reg;
    logic [LW-1:0] p1_off_reg;
    logic          p2_valid_reg;
    logic [RW-1:0] p2_row_reg;
    logic [RW-1:0] p3_row_reg;
    logic [MAX_WIDTH-1:0] occ_reg;
    logic [MAX_WIDTH-1:0] row_occ_c;
    logic [2*WW-1:0]      pair;

    logic          hit_reg;
    logic [CW-1:0] fx_reg;
    logic [RW-1:0] fy_reg;

    logic [AW-1:0] scan_a0;
    logic [AW-1:0] rd_addr0;
    logic [AW-1:0] rd_addr1;
    logic [WW-1:0] rd_data0;
    logic [WW-1:0] rd_data1;
    logic          wr_en;
    logic [WW-1:0] wr_data;
    logic [WW-1:0] wmask;
    logic [IW-1:0] mask_lo;
    logic [IW-1:0] mask_hi;
    logic [IW-1:0] word_base;
    logic [IW-1:0] bit_idx;

    gra_pkg::fit_ctl_t  fit_ctl;
    gra_pkg::fit_stat_t fit_stat;
    logic [CW-1:0]      fit_x;

    logic                            out_valid_reg;
    logic [gra_pkg::M_TDATA_W-1:0]   out_data_reg;
    logic [31:0]                     fx_wide;
    logic [31:0]                     fy_wide;

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg      <= gra_pkg::RST_GRID_WIDTH;
            gh_reg      <= gra_pkg::RST_GRID_HEIGHT;
            allowed_reg <= gra_pkg::RST_ALLOWED_CELLS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_addr)
                gra_pkg::CFG_GRID_WIDTH:    gw_reg      <= cfg_data[gra_pkg::GRID_W-1:0];
                gra_pkg::CFG_GRID_HEIGHT:   gh_reg      <= cfg_data[gra_pkg::GRID_W-1:0];
                gra_pkg::CFG_ALLOWED_CELLS: allowed_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign w_c = (32'(gw_reg) > MAX_WIDTH) ? EWW'(MAX_WIDTH) : EWW'(gw_reg);
    assign h_c = (32'(gh_reg) > MAX_HEIGHT) ? EHW'(MAX_HEIGHT) : EHW'(gh_reg);

    // ---------------------------------------------------------------- datapath helpers
    assign total_c = IW'(w_reg) * IW'(h_reg);
    assign lim_c   = base_reg + IW'(sx_reg);
    assign lim_m1  = lim_reg - IW'(1);
    assign scan_a0 = srow_reg[LW +: AW];

    assign search_empty = (w_reg == '0) || (h_reg == '0) || (sx_reg == '0) || (sy_reg == '0)
                          || (32'(sx_reg) > 32'(w_reg)) || (32'(sy_reg) > 32'(h_reg));

    assign s_axis_tready = (state_reg == ST_IDLE);

    // ---------------------------------------------------------------- state machine
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                case (op_reg)
                    gra_pkg::OP_CLEAR: state_next = ST_CLEAR;
                    gra_pkg::OP_MARK:  state_next = ST_MSET;
                    default:           state_next = search_empty ? ST_FIN : ST_SCAN;
                endcase
            end
            ST_CLEAR:
            begin
                if (wa_reg == AW'(NWORDS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_SCAN:
            begin
                if (EHW'(rq_reg) == h_reg - EHW'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!p1_valid_reg && !p2_valid_reg && !fit_stat.busy)
                begin
                    state_next = (hit_reg && op_reg == gra_pkg::OP_PLACE) ? ST_MSET : ST_FIN;
                end
            end
            ST_MSET:
            begin
                state_next = ST_MROW;
            end
            ST_MROW:
            begin
                if (ycnt_reg == sy_reg || base_reg >= total_reg || sx_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_MRD;
                end
            end
            ST_MRD:
            begin
                state_next = ST_MWR;
            end
            ST_MWR:
            begin
                state_next = (wa_reg == lim_m1[LW +: AW]) ? ST_MROW : ST_MRD;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
            srow_reg     <= '0;
            rq_reg       <= '0;
            wa_reg       <= '0;
            ycnt_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_valid_reg <= (state_reg == ST_SCAN);
            p2_valid_reg <= p1_valid_reg;

            case (state_reg)
                ST_SETUP:
                begin
                    hit_reg  <= 1'b0;
                    srow_reg <= '0;
                    rq_reg   <= '0;
                    wa_reg   <= '0;
                end
                ST_CLEAR:
                begin
                    wa_reg <= wa_reg + AW'(1);
                end
                ST_SCAN:
                begin
                    srow_reg <= srow_reg + IW'(w_reg);
                    rq_reg   <= rq_reg + RW'(1);
                end
                ST_MSET:
                begin
                    ycnt_reg <= '0;
                end
                ST_MROW:
                begin
                    wa_reg <= base_reg[LW +: AW];
                end
                ST_MWR:
                begin
                    if (wa_reg == lim_m1[LW +: AW])
                    begin
                        ycnt_reg <= ycnt_reg + SW'(1);
                    end
                    else
                    begin
                        wa_reg <= wa_reg + AW'(1);
                    end
                end
                default:
                begin
                end
            endcase

            // keep only the first row that completes a fit
            if (fit_stat.hit && !hit_reg)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_reg <= s_axis_tdata[1:0];
                    px_reg <= XW'(s_axis_tdata[5:2]);
                    py_reg <= YW'(s_axis_tdata[9:6]);
                    sx_reg <= s_axis_tdata[14:10];
                    sy_reg <= s_axis_tdata[19:15];
                    w_reg  <= w_c;
                    h_reg  <= h_c;
                end
            end
            ST_SETUP:
            begin
                total_reg <= total_c;
                if (allowed_reg == '0 || IW'(allowed_reg) >= total_c)
                begin
                    clr_lo_reg <= total_c;
                end
                else
                begin
                    clr_lo_reg <= IW'(allowed_reg);
                end
            end
            ST_DRAIN:
            begin
                px_reg <= XW'(fx_reg);
                py_reg <= YW'(fy_reg);
            end
            ST_MSET:
            begin
                base_reg <= IW'(py_reg) * IW'(w_reg) + IW'(px_reg);
            end
            ST_MROW:
            begin
                lim_reg <= (lim_c < total_reg) ? lim_c : total_reg;
            end
            ST_MWR:
            begin
                if (wa_reg == lim_m1[LW +: AW])
                begin
                    base_reg <= base_reg + IW'(w_reg);
                end
            end
            default:
            begin
            end
        endcase

        p1_row_reg <= rq_reg;
        p1_off_reg <= srow_reg[LW-1:0];
        p2_row_reg <= p1_row_reg;
        p3_row_reg <= p2_row_reg;
        occ_reg    <= row_occ_c;

        if (fit_stat.hit && !hit_reg)
        begin
            fx_reg <= fit_x;
            fy_reg <= RW'(DW'(p3_row_reg) + DW'(1) - DW'(sy_reg));
        end
    end

    // ---------------------------------------------------------------- row extract
    // a grid row starts at row * width and may straddle two memory words
    always_comb
    begin
        pair = {rd_data1, rd_data0} >> p1_off_reg;
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            row_occ_c[c] = pair[c] | (EWW'(c) >= w_reg);
        end
    end

    // ---------------------------------------------------------------- write mask
    always_comb
    begin
        mask_lo   = (state_reg == ST_CLEAR) ? clr_lo_reg : base_reg;
        mask_hi   = (state_reg == ST_CLEAR) ? total_reg : lim_reg;
        word_base = IW'(wa_reg) << LW;
        bit_idx   = word_base;
        for (int b = 0; b < WW; b++)
        begin
            bit_idx  = word_base + IW'(b);
            wmask[b] = (bit_idx >= mask_lo) && (bit_idx < mask_hi);
        end
    end

    assign rd_addr0 = (state_reg == ST_MRD) ? wa_reg : scan_a0;
    assign rd_addr1 = scan_a0 + AW'(1);
    assign wr_en    = (state_reg == ST_CLEAR) || (state_reg == ST_MWR);
    assign wr_data  = (state_reg == ST_CLEAR) ? wmask : (rd_data0 | wmask);

    gra_occ_mem #(
        .WORD_W (WW),
        .DEPTH  (NWORDS)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1),
        .wr_en    (wr_en),
        .wr_addr  (wa_reg),
        .wr_data  (wr_data)
    );

    // ---------------------------------------------------------------- fit search
    assign fit_ctl.clear     = (state_reg == ST_SETUP);
    assign fit_ctl.row_valid = p2_valid_reg;
    assign fit_ctl.size_x    = sx_reg;
    assign fit_ctl.size_y    = sy_reg;

    gra_fit #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_fit (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (fit_ctl),
        .row_occ (occ_reg),
        .stat    (fit_stat),
        .fit_x   (fit_x)
    );

    // ---------------------------------------------------------------- result beat
    assign fx_wide = hit_reg ? 32'(fx_reg) : 32'd0;
    assign fy_wide = hit_reg ? 32'(fy_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_FIN && (!out_valid_reg || m_axis_tready))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIN && (!out_valid_reg || m_axis_tready))
        begin
            out_data_reg <= {7'd0, fy_wide[3:0], fx_wide[3:0], hit_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/gra_occ_mem.sv -----
// Occupancy word memory: two registered read ports, one write port, per-word valid bits.
`default_nettype none

module gra_occ_mem #(
    parameter int WORD_W = 16,
    parameter int DEPTH  = 18,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [AW-1:0]     rd_addr0,
    input  wire logic [AW-1:0]     rd_addr1,
    output logic      [WORD_W-1:0] rd_data0,
    output logic      [WORD_W-1:0] rd_data1,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [WORD_W-1:0] wr_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    logic [WORD_W-1:0] rd_q0_reg;
    logic [WORD_W-1:0] rd_q1_reg;
    logic              rd_v0_reg;
    logic              rd_v1_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q0_reg <= mem[rd_addr0];
        rd_q1_reg <= mem[rd_addr1];
    end

    // a word never written since reset reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            rd_v0_reg <= 1'b0;
            rd_v1_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_v0_reg <= vld_reg[rd_addr0];
            rd_v1_reg <= vld_reg[rd_addr1];
        end
    end

    assign rd_data0 = rd_q0_reg & {WORD_W{rd_v0_reg}};
    assign rd_data1 = rd_q1_reg & {WORD_W{rd_v1_reg}};

endmodule

`default_nettype wire

// ----- hw/rtl/gra_fit.sv -----
// Column free-run counters and first-fit window search over one grid row per beat.
`default_nettype none

module gra_fit #(
    parameter int MAX_WIDTH = gra_pkg::DEF_MAX_WIDTH,
    localparam int CW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire gra_pkg::fit_ctl_t    ctl,
    input  wire logic [MAX_WIDTH-1:0] row_occ,
    output gra_pkg::fit_stat_t        stat,
    output logic      [CW-1:0]        fit_x
);

    localparam int SW = gra_pkg::SIZE_W;

    logic [SW-1:0]          cnt_reg [MAX_WIDTH];
    logic                   valid_d_reg;
    logic [2*MAX_WIDTH-1:0] blk_ext;
    logic [2*MAX_WIDTH-1:0] size_mask;
    logic [2*MAX_WIDTH-1:0] win;
    logic [MAX_WIDTH-1:0]   fit_vec;

    // count consecutive free rows per column, saturating at the rectangle height
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_d_reg <= 1'b0;
            for (int c = 0; c < MAX_WIDTH; c++)
            begin
                cnt_reg[c] <= '0;
            end
        end
        else
        begin
            valid_d_reg <= ctl.row_valid && !ctl.clear;
            if (ctl.clear)
            begin
                for (int c = 0; c < MAX_WIDTH; c++)
                begin
                    cnt_reg[c] <= '0;
                end
            end
            else if (ctl.row_valid)
            begin
                for (int c = 0; c < MAX_WIDTH; c++)
                begin
                    if (row_occ[c])
                    begin
                        cnt_reg[c] <= '0;
                    end
                    else if (cnt_reg[c] < ctl.size_y)
                    begin
                        cnt_reg[c] <= cnt_reg[c] + SW'(1);
                    end
                end
            end
        end
    end

    // columns past the grid edge count as blocked
    always_comb
    begin
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            blk_ext[c]             = (cnt_reg[c] < ctl.size_y);
            blk_ext[MAX_WIDTH + c] = 1'b1;
        end
        for (int i = 0; i < 2 * MAX_WIDTH; i++)
        begin
            size_mask[i] = (i < int'(ctl.size_x));
        end
        win = '0;
        for (int x = 0; x < MAX_WIDTH; x++)
        begin
            win        = (blk_ext >> x) & size_mask;
            fit_vec[x] = (win == '0);
        end
        fit_x = '0;
        for (int x = MAX_WIDTH - 1; x >= 0; x--)
        begin
            if (fit_vec[x])
            begin
                fit_x = CW'(x);
            end
        end
    end

    assign stat.busy = valid_d_reg;
    assign stat.hit  = valid_d_reg && (|fit_vec);

endmodule

`default_nettype wire

// ----- dv/grid_rect_first_fit_allocator_test.sv -----
// Self-checking testbench for the grid rectangle first-fit allocator.
`timescale 1ns / 1ps
`default_nettype none

module grid_rect_first_fit_allocator_test;

    import gra_pkg::*;

    localparam int MAX_W      = 16;
    localparam int MAX_H      = 16;
    localparam int CELLS      = MAX_W * MAX_H;
    localparam int IDLE_PCT   = 11;
    // Worst command: place = probe + full-height mark.
    localparam int SETTLE     = 250;
    localparam int PHASES     = 10;
    localparam int PHASE_CMDS = 113;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
    } grid_cmd_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] fit_x;
        logic [POS_W-1:0] fit_y;
    } fit_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    // Predicted allocator state
    bit                    cell_taken [CELLS];
    logic [GRID_W-1:0]     cur_width;
    logic [GRID_W-1:0]     cur_height;
    logic [ALLOW_W-1:0]    cur_allowed;

    fit_t                  expected_fits [$];
    int unsigned           error_count = 0;
    int unsigned           tx_idle_pct = IDLE_PCT;
    int unsigned           rx_idle_pct = IDLE_PCT;

    grid_rect_first_fit_allocator #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned grid_cols();
        return (cur_width > MAX_W) ? MAX_W : cur_width;
    endfunction

    function automatic int unsigned grid_rows();
        return (cur_height > MAX_H) ? MAX_H : cur_height;
    endfunction

    function automatic void clear_cells();
        int unsigned total;
        total = grid_cols() * grid_rows();
        foreach (cell_taken[i])
            cell_taken[i] = 1'b0;
        if (cur_allowed != 0 && cur_allowed < total)
        begin
            for (int unsigned i = cur_allowed; i < total; i++)
                cell_taken[i] = 1'b1;
        end
    endfunction

    function automatic void fill_rect(int unsigned px, int unsigned py,
                                      int unsigned sx, int unsigned sy);
        int unsigned cols;
        int unsigned total;
        int unsigned idx;
        cols  = grid_cols();
        total = cols * grid_rows();
        for (int unsigned y = 0; y < sy; y++)
        begin
            for (int unsigned x = 0; x < sx; x++)
            begin
                idx = (py + y) * cols + (px + x);
                if (idx < total)
                    cell_taken[idx] = 1'b1;
            end
        end
    endfunction

    function automatic bit rect_free(int unsigned x, int unsigned y,
                                     int unsigned sx, int unsigned sy);
        int unsigned cols;
        int unsigned total;
        int unsigned idx;
        cols  = grid_cols();
        total = cols * grid_rows();
        for (int unsigned cy = 0; cy < sy; cy++)
        begin
            for (int unsigned cx = 0; cx < sx; cx++)
            begin
                idx = (y + cy) * cols + (x + cx);
                if (idx < total && cell_taken[idx])
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic fit_t first_fit(int unsigned sx, int unsigned sy);
        fit_t        hit;
        int unsigned cols;
        int unsigned rows;
        hit  = '0;
        cols = grid_cols();
        rows = grid_rows();
        if (cols == 0 || rows == 0 || sx == 0 || sy == 0 || sx > cols || sy > rows)
            return hit;
        for (int unsigned y = 0; y + sy <= rows; y++)
        begin
            for (int unsigned x = 0; x + sx <= cols; x++)
            begin
                if (rect_free(x, y, sx, sy))
                begin
                    hit.found = 1'b1;
                    hit.fit_x = x[POS_W-1:0];
                    hit.fit_y = y[POS_W-1:0];
                    return hit;
                end
            end
        end
        return hit;
    endfunction

    // Apply one command to the predicted grid and return the result it gives.
    function automatic fit_t allocate_command(grid_cmd_t cmd);
        fit_t hit;
        hit = '0;
        case (cmd.op)
            OP_CLEAR: clear_cells();
            OP_MARK:  fill_rect(cmd.pos_x, cmd.pos_y, cmd.size_x, cmd.size_y);
            default:
            begin
                hit = first_fit(cmd.size_x, cmd.size_y);
                if (hit.found && cmd.op == OP_PLACE)
                    fill_rect(hit.fit_x, hit.fit_y, cmd.size_x, cmd.size_y);
            end
        endcase
        return hit;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (addr)
            CFG_GRID_WIDTH:    cur_width   = data[GRID_W-1:0];
            CFG_GRID_HEIGHT:   cur_height  = data[GRID_W-1:0];
            CFG_ALLOWED_CELLS: cur_allowed = data[ALLOW_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(input int unsigned cols, input int unsigned rows,
                            input int unsigned allowed);
        write_register(CFG_GRID_WIDTH, CFG_DATA_W'(cols));
        write_register(CFG_GRID_HEIGHT, CFG_DATA_W'(rows));
        write_register(CFG_ALLOWED_CELLS, CFG_DATA_W'(allowed));
    endtask

    task automatic send_command(input logic [OP_W-1:0] op,
                                input int unsigned px, input int unsigned py,
                                input int unsigned sx, input int unsigned sy);
        grid_cmd_t cmd;
        cmd.op     = op;
        cmd.pos_x  = px[POS_W-1:0];
        cmd.pos_y  = py[POS_W-1:0];
        cmd.size_x = sx[SIZE_W-1:0];
        cmd.size_y = sy[SIZE_W-1:0];
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, cmd.size_y, cmd.size_x, cmd.pos_y, cmd.pos_x, cmd.op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_fits.push_back(allocate_command(cmd));
    endtask

    // Hold the stream until every result has come back.
    task automatic wait_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_fits.size() != 0)
            @(posedge clk);
    endtask

    // Drain all results, then idle before touching registers; a place's mark ends before its result.
    task automatic wait_idle();
        wait_results();
        repeat (SETTLE) @(posedge clk);
    endtask

    // ---------------------------------------------------------------- checker

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
    begin : check_results
        fit_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_fits.size() == 0)
                report_mismatch("result beat with nothing pending", m_axis_tdata, 0);
            else
            begin
                want = expected_fits.pop_front();
                if (m_axis_tdata[0] !== want.found)
                    report_mismatch("found", m_axis_tdata[0], want.found);
                if (m_axis_tdata[4:1] !== want.fit_x)
                    report_mismatch("found_x", m_axis_tdata[4:1], want.fit_x);
                if (m_axis_tdata[8:5] !== want.fit_y)
                    report_mismatch("found_y", m_axis_tdata[8:5], want.fit_y);
                if (m_axis_tdata[15:9] !== 7'd0)
                    report_mismatch("tdata padding", m_axis_tdata[15:9], 0);
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_empty_grid();
        send_command(OP_PROBE, 0, 0, 16, 16);
        send_command(OP_PROBE, 0, 0, 0, 4);
        send_command(OP_PROBE, 0, 0, 17, 1);
        send_command(OP_PLACE, 0, 0, 31, 31);
    endtask

    task automatic test_mark_and_fit();
        send_command(OP_MARK, 0, 0, 1, 1);
        send_command(OP_PROBE, 0, 0, 1, 1);
        // spills past the right edge and off the bottom of the grid
        send_command(OP_MARK, 15, 15, 16, 16);
        send_command(OP_MARK, 14, 2, 4, 1);
        send_command(OP_PLACE, 0, 0, 4, 4);
        send_command(OP_PLACE, 0, 0, 4, 4);
        send_command(OP_PROBE, 0, 0, 2, 3);
        send_command(OP_CLEAR, 0, 0, 0, 0);
        send_command(OP_PLACE, 0, 0, 16, 16);
        send_command(OP_PROBE, 0, 0, 1, 1);
    endtask

    task automatic test_allowed_limit();
        wait_idle();
        set_grid(16, 16, 200);
        send_command(OP_CLEAR, 0, 0, 0, 0);
        send_command(OP_PROBE, 0, 0, 16, 13);
        send_command(OP_PROBE, 0, 0, 8, 13);
        wait_idle();
        set_grid(16, 16, 256);
        send_command(OP_CLEAR, 0, 0, 0, 0);
        send_command(OP_PROBE, 0, 0, 16, 16);
    endtask

    task automatic test_grid_dimensions();
        wait_idle();
        set_grid(1, 1, 1);
        send_command(OP_CLEAR, 0, 0, 0, 0);
        send_command(OP_PLACE, 0, 0, 1, 1);
        send_command(OP_PROBE, 0, 0, 1, 1);
        wait_idle();
        set_grid(0, 16, 0);
        send_command(OP_PROBE, 0, 0, 1, 1);
        wait_idle();
        set_grid(31, 31, 511);
        send_command(OP_CLEAR, 0, 0, 0, 0);
        send_command(OP_PLACE, 0, 0, 16, 2);
        // shrink the grid: the marked bits keep their linear index
        wait_idle();
        set_grid(8, 4, 0);
        send_command(OP_PROBE, 0, 0, 2, 2);
    endtask

    function automatic int unsigned pick_size(int unsigned limit);
        int unsigned roll;
        int unsigned top;
        roll = $urandom_range(99);
        top  = (limit == 0) ? 1 : limit;
        if (roll < 8)
            return $urandom_range(0, 31);
        if (roll < 22)
            return $urandom_range(1, top);
        return $urandom_range(1, (top < 4) ? top : 4);
    endfunction

    task automatic test_random_traffic();
        int unsigned preset_cols [PHASES] = '{16, 1, 16, 1, 31, 0, 5, 16, 8, 16};
        int unsigned preset_rows [PHASES] = '{16, 1, 1, 16, 31, 8, 7, 16, 16, 0};
        int unsigned preset_allow[PHASES] = '{0, 0, 9, 1, 511, 3, 20, 256, 100, 0};
        int unsigned cols;
        int unsigned rows;
        int unsigned allowed;
        int unsigned roll;
        logic [OP_W-1:0] op;
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            cols    = preset_cols[p];
            rows    = preset_rows[p];
            allowed = preset_allow[p];
            if (p == 6)
            begin
                cols    = $urandom_range(0, 31);
                rows    = $urandom_range(1, 31);
                allowed = $urandom_range(0, 511);
            end
            // upper data bits are dropped by the narrow registers
            write_register(CFG_GRID_WIDTH, CFG_DATA_W'(cols | ($urandom_range(15) << 5)));
            write_register(CFG_GRID_HEIGHT, CFG_DATA_W'(rows | ($urandom_range(15) << 5)));
            write_register(CFG_ALLOWED_CELLS, CFG_DATA_W'(allowed));
            if (p == 4)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else
            begin
                tx_idle_pct = IDLE_PCT;
                rx_idle_pct = IDLE_PCT;
            end
            send_command(OP_CLEAR, 0, 0, 0, 0);
            for (int i = 0; i < PHASE_CMDS; i++)
            begin
                if (p == 2 && i == PHASE_CMDS / 2)
                    wait_results();
                roll = $urandom_range(99);
                if (roll < 4)
                    op = OP_CLEAR;
                else if (roll < 22)
                    op = OP_MARK;
                else if (roll < 50)
                    op = OP_PROBE;
                else
                    op = OP_PLACE;
                send_command(op, $urandom_range(15), $urandom_range(15),
                             pick_size(grid_cols()), pick_size(grid_rows()));
            end
        end
    endtask

    initial
    begin
        cur_width   = RST_GRID_WIDTH;
        cur_height  = RST_GRID_HEIGHT;
        cur_allowed = RST_ALLOWED_CELLS;
        foreach (cell_taken[i])
            cell_taken[i] = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_grid();
        test_mark_and_fit();
        test_allowed_limit();
        test_grid_dimensions();
        test_random_traffic();
        wait_idle();

        if (error_count == 0)
            $display("grid_rect_first_fit_allocator_test: clean");
        else
            $display("grid_rect_first_fit_allocator_test: errors");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("grid_rect_first_fit_allocator_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
